[design/linear_interp_resampler_assert.svh]
// assertion macros for the linear interpolation resampler
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LIR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lir assertion failed");

// next-cycle implication, checked outside reset
`define LIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lir assertion failed");

`endif

[design/lir_pkg.sv]
// shared constants and control types of the linear interpolation resampler
`timescale 1ns / 1ps
package lir_pkg;

  localparam int SampleW = 16;
  localparam int StepW   = 18;
  localparam int PhaseW  = 18;

  localparam logic [StepW-1:0]  StepMin   = 18'd8192;
  localparam logic [StepW-1:0]  StepMax   = 18'd131072;
  localparam logic [StepW-1:0]  StepReset = 18'd65536;
  localparam logic [PhaseW-1:0] OneQ16    = 18'd65536;

  typedef struct packed {
    logic latch_in;
    logic mul;
    logic tail_sel;
    logic sum;
    logic produce;
    logic bypass_sel;
    logic phase_add;
    logic phase_sub;
    logic phase_one;
    logic finish;
  } lir_cmd_t;

  typedef struct packed {
    logic bypass;
    logic have_prev;
    logic phase_lt_one;
    logic tail_ok;
    logic last;
    logic pend_valid;
    logic can_produce;
    logic can_finish;
  } lir_sts_t;

endpackage

[design/lir_ctrl.sv]
// control state machine: walks the output positions of one input beat
`timescale 1ns / 1ps
module lir_ctrl
  import lir_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lir_sts_t sts_i,
  output lir_cmd_t cmd_o
);

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StDispatch = 4'd1;
  localparam logic [3:0] StBypass   = 4'd2;
  localparam logic [3:0] StInterp   = 4'd3;
  localparam logic [3:0] StTail     = 4'd4;
  localparam logic [3:0] StMul      = 4'd5;
  localparam logic [3:0] StSum      = 4'd6;
  localparam logic [3:0] StScale    = 4'd7;
  localparam logic [3:0] StFinish   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       tail_q, tail_d;

  always_comb begin
    state_d    = state_q;
    tail_d     = tail_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = StDispatch;
        end
      end
      StDispatch: begin
        if (sts_i.bypass) begin
          state_d = StBypass;
        end else if (sts_i.have_prev) begin
          state_d = StInterp;
        end else begin
          state_d = StTail;
        end
      end
      StBypass: begin
        if (sts_i.can_produce) begin
          cmd_o.produce    = 1'b1;
          cmd_o.bypass_sel = 1'b1;
          cmd_o.phase_one  = 1'b1;
          state_d          = StFinish;
        end
      end
      StInterp: begin
        if (sts_i.phase_lt_one) begin
          tail_d  = 1'b0;
          state_d = StMul;
        end else begin
          cmd_o.phase_sub = 1'b1;
          state_d         = StTail;
        end
      end
      StTail: begin
        if (sts_i.last && sts_i.tail_ok) begin
          tail_d  = 1'b1;
          state_d = StMul;
        end else begin
          state_d = StFinish;
        end
      end
      StMul: begin
        cmd_o.mul      = 1'b1;
        cmd_o.tail_sel = tail_q;
        state_d        = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StScale;
      end
      StScale: begin
        if (sts_i.can_produce) begin
          cmd_o.produce   = 1'b1;
          cmd_o.phase_add = 1'b1;
          state_d         = tail_q ? StTail : StInterp;
        end
      end
      StFinish: begin
        if (sts_i.can_finish) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tail_q  <= tail_d;
    end
  end

endmodule

[design/lir_dp.sv]
// datapath: step register, phase, interpolation and scaling, held and output beats
`timescale 1ns / 1ps
module lir_dp
  import lir_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [StepW-1:0]          cfg_wr_data_i,
  input  logic signed [SampleW-1:0] in_sample_i,
  input  logic                      in_last_i,
  input  lir_cmd_t                  cmd_i,
  output lir_sts_t                  sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] out_sample_o,
  output logic                      out_last_o
);

  logic [StepW-1:0]          step_cfg_q;
  logic [StepW-1:0]          step_eff;
  logic signed [SampleW-1:0] cur_q, prev_q, pend_q, a_q;
  logic                      last_q, have_prev_q, pend_valid_q;
  logic [PhaseW-1:0]         phase_q;
  logic signed [SampleW:0]   diff;
  logic signed [2*SampleW+1:0] prod_q;
  logic signed [2*SampleW+1:0] sum_full;
  logic signed [2*SampleW-1:0] v_q;
  logic signed [47:0]        v_ext, w, w_bias;
  logic signed [SampleW-1:0] scaled, prod_val;
  logic [PhaseW+1:0]         tail_sum;
  logic                      out_free, push, push_last;
  logic                      out_valid_q, out_last_q;
  logic signed [SampleW-1:0] out_sample_q;

  always_comb begin
    if (step_cfg_q < StepMin) begin
      step_eff = StepMin;
    end else if (step_cfg_q > StepMax) begin
      step_eff = StepMax;
    end else begin
      step_eff = step_cfg_q;
    end
  end

  assign diff     = {cur_q[SampleW-1], cur_q} - {prev_q[SampleW-1], prev_q};
  assign sum_full = {{2{a_q[SampleW-1]}}, a_q, 16'd0} + prod_q;
  assign v_ext    = {{16{v_q[2*SampleW-1]}}, v_q};
  assign w        = (v_ext <<< 15) - v_ext;
  assign w_bias   = w[47] ? (w + 48'sh0000_7FFF_FFFF) : w;
  assign scaled   = w_bias[46:31];
  assign prod_val = cmd_i.bypass_sel ? cur_q : scaled;
  assign tail_sum = {1'b0, phase_q, 1'b0} + {2'b00, step_eff};

  assign out_free  = !out_valid_q || out_ready_i;
  assign push_last = cmd_i.finish && last_q && pend_valid_q;
  assign push      = (cmd_i.produce && pend_valid_q) || push_last;

  assign sts_o.bypass       = (step_eff == OneQ16);
  assign sts_o.have_prev    = have_prev_q;
  assign sts_o.phase_lt_one = (phase_q < OneQ16);
  assign sts_o.tail_ok      = (tail_sum <= {1'b0, OneQ16, 1'b0});
  assign sts_o.last         = last_q;
  assign sts_o.pend_valid   = pend_valid_q;
  assign sts_o.can_produce  = !pend_valid_q || out_free;
  assign sts_o.can_finish   = !(last_q && pend_valid_q) || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cfg_q   <= StepReset;
      have_prev_q  <= 1'b0;
      phase_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        step_cfg_q <= cfg_wr_data_i;
      end
      if (cmd_i.phase_add) begin
        phase_q <= phase_q + step_eff;
      end else if (cmd_i.phase_sub) begin
        phase_q <= phase_q - OneQ16;
      end else if (cmd_i.phase_one) begin
        phase_q <= OneQ16;
      end else if (cmd_i.finish && last_q) begin
        phase_q <= '0;
      end
      if (cmd_i.finish) begin
        have_prev_q <= !last_q;
      end
      if (cmd_i.produce) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.finish && last_q) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cur_q  <= in_sample_i;
      last_q <= in_last_i;
    end
    if (cmd_i.finish) begin
      prev_q <= cur_q;
    end
    if (cmd_i.mul) begin
      a_q <= cmd_i.tail_sel ? cur_q : prev_q;
      if (cmd_i.tail_sel) begin
        prod_q <= '0;
      end else begin
        prod_q <= $signed({1'b0, phase_q[15:0]}) * diff;
      end
    end
    if (cmd_i.sum) begin
      v_q <= sum_full[2*SampleW-1:0];
    end
    if (cmd_i.produce) begin
      pend_q <= prod_val;
    end
    if (push) begin
      out_sample_q <= pend_q;
      out_last_q   <= push_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;

endmodule

[design/linear_interp_resampler.sv]
// Linear interpolation resampler. One block of signed 16-bit samples comes in, one per beat,
// the final one with tlast; outputs at source positions 0, step, 2*step... come out as
// a + t*(b - a) scaled by 32767/32768, truncated toward zero, with tlast on the block's final
// output. step_q16 (Q2.16, clamped to 8192..131072) is written through cfg_wr_en_i; the
// user must write it only while idle, the block does not enforce this. At exactly 1.0
// samples pass unchanged. One input beat is taken at a time: a new beat is accepted only
// after the last one is finished; each interpolated output walks through the shared
// multiply, sum and scale path, and a stall on the output side holds the beat.
`timescale 1ns / 1ps
`include "linear_interp_resampler_assert.svh"
module linear_interp_resampler
  import lir_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [StepW-1:0]   cfg_wr_data_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [SampleW-1:0] s_axis_tdata_i,  // [15:0] sample
  input  logic               s_axis_tlast_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [SampleW-1:0] m_axis_tdata_o,  // [15:0] out_sample
  output logic               m_axis_tlast_o
);

  lir_cmd_t                  cmd;
  lir_sts_t                  sts;
  logic signed [SampleW-1:0] out_sample;

  lir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lir_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_sample_i   ($signed(s_axis_tdata_i)),
    .in_last_i     (s_axis_tlast_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_sample_o  (out_sample),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_sample;

  // one input beat in flight at a time
  `LIR_ASSERT_NEXT(a_one_beat, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // a held output between beats always belongs to an open block
  `LIR_ASSERT_NOW(a_pend_in_block, s_axis_tready_o && sts.pend_valid, sts.have_prev)
  // the final output of a block leaves nothing held behind
  `LIR_ASSERT_NEXT(a_final_clears, cmd.finish && sts.last, !sts.pend_valid && !sts.have_prev)

endmodule
